[design/sivu_pkg.sv]
package sivu_pkg;

  localparam int unsigned NumVregsDefault   = 32;
  localparam int unsigned VectorBitsDefault = 128;

  typedef enum logic [3:0] {
    OP_DUP       = 4'd0,
    OP_INS       = 4'd1,
    OP_MOVI      = 4'd2,
    OP_MOVI_SH   = 4'd3,
    OP_MOVI_ONES = 4'd4,
    OP_FMOV      = 4'd5,
    OP_ORR       = 4'd6,
    OP_AND       = 4'd7,
    OP_ADD       = 4'd8,
    OP_ADDP      = 4'd9,
    OP_CMEQ      = 4'd10,
    OP_CMEQZ     = 4'd11,
    OP_UMOV      = 4'd12,
    OP_SMOV      = 4'd13
  } op_kind_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  dest_reg;
    logic [4:0]  src_n;
    logic [4:0]  src_m;
    logic [1:0]  elem_size;
    logic        full_width;
    logic [3:0]  lane_index;
    logic [7:0]  imm8;
    logic [1:0]  shift_amount;
    logic [63:0] gp_value;
    logic        wide_result;
  } in_item_t;

  typedef struct packed {
    logic [63:0] gp_result;
    logic        gp_valid;
  } out_item_t;

  // replicate a lane value of the given size across 64 bits
  function automatic logic [63:0] replicate(input logic [63:0] v, input logic [1:0] es);
    logic [63:0] r;
    begin
      case (es)
        2'd0:    r = {8{v[7:0]}};
        2'd1:    r = {4{v[15:0]}};
        2'd2:    r = {2{v[31:0]}};
        default: r = v;
      endcase
      return r;
    end
  endfunction

  // lane-wise add with carries broken at lane boundaries
  function automatic logic [63:0] lane_add(input logic [63:0] a, input logic [63:0] b,
                                           input logic [1:0] es);
    logic [63:0] r;
    begin
      r = '0;
      case (es)
        2'd0: for (int i = 0; i < 8; i++) r[i*8 +: 8] = a[i*8 +: 8] + b[i*8 +: 8];
        2'd1: for (int i = 0; i < 4; i++) r[i*16 +: 16] = a[i*16 +: 16] + b[i*16 +: 16];
        2'd2: for (int i = 0; i < 2; i++) r[i*32 +: 32] = a[i*32 +: 32] + b[i*32 +: 32];
        default: r = a + b;
      endcase
      return r;
    end
  endfunction

  // lane-wise equality mask
  function automatic logic [63:0] lane_eq(input logic [63:0] a, input logic [63:0] b,
                                          input logic [1:0] es);
    logic [63:0] r;
    begin
      r = '0;
      case (es)
        2'd0: for (int i = 0; i < 8; i++) r[i*8 +: 8] = {8{a[i*8 +: 8] == b[i*8 +: 8]}};
        2'd1: for (int i = 0; i < 4; i++)
                r[i*16 +: 16] = {16{a[i*16 +: 16] == b[i*16 +: 16]}};
        2'd2: for (int i = 0; i < 2; i++)
                r[i*32 +: 32] = {32{a[i*32 +: 32] == b[i*32 +: 32]}};
        default: r = {64{a == b}};
      endcase
      return r;
    end
  endfunction

  // pairwise sums of one 128-bit source packed into 64 bits
  function automatic logic [63:0] pair_add(input logic [127:0] a, input logic [1:0] es);
    logic [63:0] r;
    begin
      r = '0;
      case (es)
        2'd0: for (int i = 0; i < 8; i++) r[i*8 +: 8] = a[i*16 +: 8] + a[i*16+8 +: 8];
        2'd1: for (int i = 0; i < 4; i++) r[i*16 +: 16] = a[i*32 +: 16] + a[i*32+16 +: 16];
        2'd2: for (int i = 0; i < 2; i++) r[i*32 +: 32] = a[i*64 +: 32] + a[i*64+32 +: 32];
        default: r = a[63:0] + a[127:64];
      endcase
      return r;
    end
  endfunction

  // pairwise sums of the low 64 bits, half a word
  function automatic logic [31:0] pair_add_half(input logic [63:0] a, input logic [1:0] es);
    logic [31:0] r;
    begin
      r = '0;
      case (es)
        2'd0: for (int i = 0; i < 4; i++) r[i*8 +: 8] = a[i*16 +: 8] + a[i*16+8 +: 8];
        2'd1: for (int i = 0; i < 2; i++) r[i*16 +: 16] = a[i*32 +: 16] + a[i*32+16 +: 16];
        2'd2: r = a[31:0] + a[63:32];
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

[design/sivu_regfile.sv]
module sivu_regfile #(
  parameter int unsigned NUM_VREGS   = sivu_pkg::NumVregsDefault,
  parameter int unsigned VECTOR_BITS = sivu_pkg::VectorBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [4:0]             rd_a_addr,
  input  logic [4:0]             rd_b_addr,
  input  logic [4:0]             rd_c_addr,
  output logic [VECTOR_BITS-1:0] rd_a_data,
  output logic [VECTOR_BITS-1:0] rd_b_data,
  output logic [VECTOR_BITS-1:0] rd_c_data,
  input  logic                   wr_en,
  input  logic [4:0]             wr_addr,
  input  logic [VECTOR_BITS-1:0] wr_data
);

  logic [VECTOR_BITS-1:0] regs_r [NUM_VREGS];

  // register file in flops, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VREGS; i++) regs_r[i] <= '0;
    end else if (wr_en && (32'(wr_addr) < NUM_VREGS)) begin
      for (int i = 0; i < NUM_VREGS; i++)
        if (32'(wr_addr) == i) regs_r[i] <= wr_data;
    end
  end

  // read ports; out of range registers read as zero
  always_comb begin
    rd_a_data = '0;
    rd_b_data = '0;
    rd_c_data = '0;
    for (int i = 0; i < NUM_VREGS; i++) begin
      if (32'(rd_a_addr) == i) rd_a_data = regs_r[i];
      if (32'(rd_b_addr) == i) rd_b_data = regs_r[i];
      if (32'(rd_c_addr) == i) rd_c_data = regs_r[i];
    end
  end

endmodule

[design/sivu_exec.sv]
module sivu_exec (
  input  sivu_pkg::in_item_t item,
  input  logic [127:0]       src_a,
  input  logic [127:0]       src_b,
  input  logic [127:0]       src_d,
  output logic               wr_en,
  output logic [127:0]       wr_data,
  output sivu_pkg::out_item_t res
);

  logic [1:0]   es;
  logic [3:0]   lidx;
  logic [63:0]  gp_rep;
  logic [63:0]  imm_v;
  logic [63:0]  movi_rep;
  logic [63:0]  lane_m;
  logic [6:0]   sh;
  logic [127:0] ins_mask;
  logic [127:0] lane_word;
  logic [63:0]  ext_v;
  logic [127:0] d;
  logic [31:0]  fv;
  logic [63:0]  pa;
  logic [63:0]  pb;
  logic [31:0]  pha;
  logic [31:0]  phb;

  assign es = item.elem_size;

  always_comb begin
    // lane mask, masked lane index and bit offset
    case (es)
      2'd0:    lane_m = 64'hFF;
      2'd1:    lane_m = 64'hFFFF;
      2'd2:    lane_m = 64'hFFFF_FFFF;
      default: lane_m = '1;
    endcase
    case (es)
      2'd0:    lidx = item.lane_index;
      2'd1:    lidx = {1'b0, item.lane_index[2:0]};
      2'd2:    lidx = {2'b0, item.lane_index[1:0]};
      default: lidx = {3'b0, item.lane_index[0]};
    endcase
    sh = 7'({3'b0, lidx} << (3 + 32'(es)));

    // movi immediate value
    imm_v = '0;
    case (item.kind)
      sivu_pkg::OP_MOVI:
        if (es == 2'd3)
          for (int i = 0; i < 8; i++) imm_v[i*8 +: 8] = {8{item.imm8[i]}};
        else imm_v = {56'b0, item.imm8};
      sivu_pkg::OP_MOVI_SH: imm_v = {56'b0, item.imm8} << {item.shift_amount, 3'b0};
      default:
        imm_v = item.shift_amount[0] ? {40'b0, item.imm8, 16'hFFFF}
                                     : {48'b0, item.imm8, 8'hFF};
    endcase
    movi_rep = sivu_pkg::replicate(imm_v & lane_m, es);
    gp_rep   = sivu_pkg::replicate(item.gp_value & lane_m, es);

    fv = {item.imm8[7], ~item.imm8[6], {5{item.imm8[6]}}, item.imm8[5:0], 19'b0};

    ins_mask  = {64'b0, lane_m} << sh;
    lane_word = src_a >> sh;

    pa  = sivu_pkg::pair_add(src_a, es);
    pb  = sivu_pkg::pair_add(src_b, es);
    pha = sivu_pkg::pair_add_half(src_a[63:0], es);
    phb = sivu_pkg::pair_add_half(src_b[63:0], es);

    // datapath per operation
    wr_en = 1'b1;
    d     = '0;
    case (item.kind)
      sivu_pkg::OP_DUP:  d = {gp_rep, gp_rep};
      sivu_pkg::OP_INS:  d = (src_d & ~ins_mask) | (({64'b0, item.gp_value} << sh) & ins_mask);
      sivu_pkg::OP_MOVI, sivu_pkg::OP_MOVI_SH, sivu_pkg::OP_MOVI_ONES:
        d = {movi_rep, movi_rep};
      sivu_pkg::OP_FMOV: d = {fv, fv, fv, fv};
      sivu_pkg::OP_ORR:  d = src_a | src_b;
      sivu_pkg::OP_AND:  d = src_a & src_b;
      sivu_pkg::OP_ADD:
        d = {sivu_pkg::lane_add(src_a[127:64], src_b[127:64], es),
             sivu_pkg::lane_add(src_a[63:0], src_b[63:0], es)};
      sivu_pkg::OP_ADDP: d = item.full_width ? {pb, pa} : {64'b0, phb, pha};
      sivu_pkg::OP_CMEQ:
        d = {sivu_pkg::lane_eq(src_a[127:64], src_b[127:64], es),
             sivu_pkg::lane_eq(src_a[63:0], src_b[63:0], es)};
      sivu_pkg::OP_CMEQZ:
        d = {sivu_pkg::lane_eq(src_a[127:64], 64'b0, es),
             sivu_pkg::lane_eq(src_a[63:0], 64'b0, es)};
      default: wr_en = 1'b0;
    endcase
    // half width clears the upper 64 bits; ins keeps every other lane
    if (!item.full_width && (item.kind != sivu_pkg::OP_INS)) d[127:64] = '0;
    wr_data = d;

    // lane extraction with optional sign extension
    ext_v = lane_word[63:0] & lane_m;
    if (item.kind == sivu_pkg::OP_SMOV) begin
      case (es)
        2'd0:    ext_v = {{56{ext_v[7]}}, ext_v[7:0]};
        2'd1:    ext_v = {{48{ext_v[15]}}, ext_v[15:0]};
        2'd2:    ext_v = {{32{ext_v[31]}}, ext_v[31:0]};
        default: ext_v = ext_v;
      endcase
    end
    if (!item.wide_result) ext_v[63:32] = '0;
    res.gp_valid  = (item.kind == sivu_pkg::OP_UMOV) || (item.kind == sivu_pkg::OP_SMOV);
    res.gp_result = res.gp_valid ? ext_v : 64'b0;
  end

endmodule

[design/simd_integer_vector_unit.sv]
// channel | ports                        | direction
// input   | in_valid, in_stall, in_item  | decoded instruction in
// result  | out_valid, out_stall, out_item | general result out
// an item is taken every cycle while the result stage can move
// the register file is read combinationally and written at the edge an item leaves
// the input register, so the next item already sees the update
// reset clears all vector registers and both valid flags
// out_stall holds the result register; the input register then accepts one item behind it
module simd_integer_vector_unit #(
  parameter int unsigned NUM_VREGS   = sivu_pkg::NumVregsDefault,
  parameter int unsigned VECTOR_BITS = sivu_pkg::VectorBitsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sivu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sivu_pkg::out_item_t out_item
);

  logic                 stg_valid_r;
  sivu_pkg::in_item_t   stg_item_r;
  logic                 out_valid_r;
  sivu_pkg::out_item_t  out_item_r;
  logic                 adv;
  logic                 wr_en;
  logic [127:0]         wr_data;
  logic [VECTOR_BITS-1:0] ra, rb, rc;
  sivu_pkg::out_item_t  res;

  // an item leaves the input stage when the result register is free
  assign adv      = stg_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stg_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) stg_valid_r <= 1'b1;
      else if (adv)              stg_valid_r <= 1'b0;
      if (adv)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) stg_item_r <= in_item;
    if (adv)                   out_item_r <= res;
  end

  sivu_regfile #(.NUM_VREGS(NUM_VREGS), .VECTOR_BITS(VECTOR_BITS)) u_rf (
    .clk(clk), .rst_n(rst_n),
    .rd_a_addr(stg_item_r.src_n), .rd_b_addr(stg_item_r.src_m),
    .rd_c_addr(stg_item_r.dest_reg),
    .rd_a_data(ra), .rd_b_data(rb), .rd_c_data(rc),
    .wr_en(wr_en && adv), .wr_addr(stg_item_r.dest_reg), .wr_data(wr_data)
  );

  sivu_exec u_exec (
    .item(stg_item_r), .src_a(ra), .src_b(rb), .src_d(rc),
    .wr_en(wr_en), .wr_data(wr_data), .res(res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[test/simd_integer_vector_unit_test.sv]
`timescale 1ns / 100ps

module simd_integer_vector_unit_test;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sivu_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  sivu_pkg::out_item_t out_item;

  simd_integer_vector_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // shadow vector file and expected general results
  logic [127:0]        shadow_vregs [32];
  sivu_pkg::out_item_t pending_results [$];
  int                  error_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_reqs;
  int                  hold_seen;
  int                  hold_left;

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic logic [63:0] mask_of(input logic [1:0] es);
    return (es == 2'd3) ? '1 : ((64'd1 << (8 << es)) - 64'd1);
  endfunction

  function automatic logic [63:0] lane_read(input logic [127:0] v, input logic [1:0] es,
                                             input int idx);
    int w;
    w = 8 << es;
    idx = idx & ((16 >> es) - 1);
    return 64'(v >> (idx * w)) & mask_of(es);
  endfunction

  function automatic logic [127:0] lane_write(input logic [127:0] v, input logic [1:0] es,
                                              input int idx, input logic [63:0] x);
    int w;
    logic [127:0] m;
    w = 8 << es;
    idx = idx & ((16 >> es) - 1);
    m = {64'd0, mask_of(es)} << (idx * w);
    return (v & ~m) | (({64'd0, x} << (idx * w)) & m);
  endfunction

  // apply one instruction to the shadow file and give its general result
  function automatic sivu_pkg::out_item_t simd_predict(input sivu_pkg::in_item_t it);
    sivu_pkg::out_item_t res;
    logic [127:0] a, b, d;
    logic [63:0]  v, other;
    int           lanes, half, n;
    logic         wr;
    res = '0;
    a = shadow_vregs[it.src_n];
    b = shadow_vregs[it.src_m];
    d = '0;
    wr = 1'b1;
    lanes = (it.full_width ? 16 : 8) >> it.elem_size;
    v = '0;
    case (it.kind)
      sivu_pkg::OP_DUP: for (int i = 0; i < lanes; i++)
        d = lane_write(d, it.elem_size, i, it.gp_value);
      sivu_pkg::OP_INS: d = lane_write(shadow_vregs[it.dest_reg], it.elem_size,
                                       it.lane_index, it.gp_value);
      sivu_pkg::OP_MOVI, sivu_pkg::OP_MOVI_SH, sivu_pkg::OP_MOVI_ONES: begin
        if (it.kind == sivu_pkg::OP_MOVI) begin
          if (it.elem_size == 2'd3) begin
            for (int i = 0; i < 8; i++) if (it.imm8[i]) v[i*8 +: 8] = 8'hff;
          end else v = 64'(it.imm8);
        end else if (it.kind == sivu_pkg::OP_MOVI_SH) begin
          v = 64'(it.imm8) << (8 * it.shift_amount);
        end else begin
          n = 8 * (it.shift_amount[0] + 1);
          v = (64'(it.imm8) << n) | ((64'd1 << n) - 64'd1);
        end
        for (int i = 0; i < lanes; i++) d = lane_write(d, it.elem_size, i, v);
      end
      sivu_pkg::OP_FMOV: begin
        v = (it.imm8[7] ? 64'h8000_0000 : 64'd0)
          | (it.imm8[6] ? 64'h3e00_0000 : 64'h4000_0000)
          | (64'(it.imm8[5:0]) << 19);
        for (int i = 0; i < (it.full_width ? 4 : 2); i++) d = lane_write(d, 2'd2, i, v);
      end
      sivu_pkg::OP_ORR: d = it.full_width ? (a | b) : {64'd0, a[63:0] | b[63:0]};
      sivu_pkg::OP_AND: d = it.full_width ? (a & b) : {64'd0, a[63:0] & b[63:0]};
      sivu_pkg::OP_ADD: for (int i = 0; i < lanes; i++)
        d = lane_write(d, it.elem_size, i,
                       lane_read(a, it.elem_size, i) + lane_read(b, it.elem_size, i));
      sivu_pkg::OP_ADDP: begin
        half = lanes / 2;
        for (int i = 0; i < half; i++) begin
          d = lane_write(d, it.elem_size, i, lane_read(a, it.elem_size, 2*i)
                         + lane_read(a, it.elem_size, 2*i + 1));
          d = lane_write(d, it.elem_size, i + half, lane_read(b, it.elem_size, 2*i)
                         + lane_read(b, it.elem_size, 2*i + 1));
        end
      end
      sivu_pkg::OP_CMEQ, sivu_pkg::OP_CMEQZ: for (int i = 0; i < lanes; i++) begin
        other = (it.kind == sivu_pkg::OP_CMEQ) ? lane_read(b, it.elem_size, i) : 64'd0;
        d = lane_write(d, it.elem_size, i,
                       (lane_read(a, it.elem_size, i) == other) ? mask_of(it.elem_size)
                                                                : 64'd0);
      end
      sivu_pkg::OP_UMOV, sivu_pkg::OP_SMOV: begin
        wr = 1'b0;
        v = lane_read(a, it.elem_size, it.lane_index);
        if (it.kind == sivu_pkg::OP_SMOV && it.elem_size != 2'd3
            && v[(8 << it.elem_size) - 1])
          v = v | ~mask_of(it.elem_size);
        if (!it.wide_result) v = v & 64'hffff_ffff;
        res.gp_result = v;
        res.gp_valid  = 1'b1;
      end
      default: wr = 1'b0;
    endcase
    if (wr) shadow_vregs[it.dest_reg] = d;
    return res;
  endfunction

  // send one item and record its expected result on acceptance
  task automatic send_item(input sivu_pkg::in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(simd_predict(it));
  endtask

  function automatic sivu_pkg::in_item_t rand_item();
    sivu_pkg::in_item_t it;
    it = '0;
    it.kind         = 4'($urandom_range(15));
    if ($urandom_range(9) < 8) it.kind = 4'($urandom_range(13));
    it.dest_reg     = 5'($urandom);
    it.src_n        = 5'($urandom);
    it.src_m        = 5'($urandom);
    // keep registers in a small pool now and then so results build on each other
    if ($urandom_range(1)) begin
      it.dest_reg = 5'($urandom_range(3));
      it.src_n    = 5'($urandom_range(3));
      it.src_m    = 5'($urandom_range(3));
    end
    it.elem_size    = 2'($urandom);
    it.full_width   = 1'($urandom);
    it.lane_index   = 4'($urandom);
    it.imm8         = 8'($urandom);
    it.shift_amount = 2'($urandom);
    it.gp_value     = {$urandom, $urandom};
    it.wide_result  = 1'($urandom);
    return it;
  endfunction

  function automatic sivu_pkg::in_item_t make_item(input sivu_pkg::op_kind_t k, input int rd,
                                                   input int rn, input int rm, input int es,
                                                   input logic full);
    sivu_pkg::in_item_t it;
    it = '0;
    it.kind = k; it.dest_reg = 5'(rd); it.src_n = 5'(rn); it.src_m = 5'(rm);
    it.elem_size = 2'(es); it.full_width = full;
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    sivu_pkg::out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_item.gp_result !== exp_res.gp_result)
          $display("%0t: gp_result expected %h actual %h", $time, exp_res.gp_result,
                   out_item.gp_result);
        if (out_item.gp_valid !== exp_res.gp_valid)
          $display("%0t: gp_valid expected %b actual %b", $time, exp_res.gp_valid,
                   out_item.gp_valid);
        if (out_item !== exp_res) error_count++;
      end
    end
  end

  // receiver stall, with a long hold-off counted here on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 40;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // directed: every operation at the field extremes and special cases
  task automatic test_directed();
    sivu_pkg::in_item_t it;
    it = make_item(sivu_pkg::OP_DUP, 1, 0, 0, 0, 1'b1); it.gp_value = '1; send_item(it);
    it = make_item(sivu_pkg::OP_DUP, 2, 0, 0, 3, 1'b0);
    it.gp_value = 64'h8000_0000_0000_0001; send_item(it);
    it = make_item(sivu_pkg::OP_INS, 2, 0, 0, 0, 1'b0); it.lane_index = 4'd15;
    it.gp_value = 64'h5a; send_item(it);
    it = make_item(sivu_pkg::OP_INS, 31, 0, 0, 3, 1'b1); it.lane_index = 4'd3;
    it.gp_value = 64'h1234_5678_9abc_def0; send_item(it);
    it = make_item(sivu_pkg::OP_MOVI, 3, 0, 0, 3, 1'b1); it.imm8 = 8'ha5; send_item(it);
    it = make_item(sivu_pkg::OP_MOVI, 4, 0, 0, 0, 1'b0); it.imm8 = 8'hff; send_item(it);
    it = make_item(sivu_pkg::OP_MOVI_SH, 5, 0, 0, 1, 1'b1); it.imm8 = 8'hff;
    it.shift_amount = 2'd3; send_item(it);
    it = make_item(sivu_pkg::OP_MOVI_ONES, 6, 0, 0, 2, 1'b1); it.imm8 = 8'h81;
    it.shift_amount = 2'd3; send_item(it);
    it = make_item(sivu_pkg::OP_FMOV, 7, 0, 0, 0, 1'b1); it.imm8 = 8'hc0; send_item(it);
    it = make_item(sivu_pkg::OP_FMOV, 8, 0, 0, 3, 1'b0); it.imm8 = 8'h3f; send_item(it);
    send_item(make_item(sivu_pkg::OP_ORR, 9, 1, 3, 0, 1'b1));
    send_item(make_item(sivu_pkg::OP_AND, 10, 1, 3, 0, 1'b0));
    send_item(make_item(sivu_pkg::OP_ADD, 11, 1, 1, 0, 1'b1));
    send_item(make_item(sivu_pkg::OP_ADD, 12, 2, 31, 3, 1'b1));
    send_item(make_item(sivu_pkg::OP_ADDP, 13, 1, 3, 1, 1'b1));
    send_item(make_item(sivu_pkg::OP_ADDP, 14, 1, 3, 3, 1'b0));
    send_item(make_item(sivu_pkg::OP_CMEQ, 15, 1, 1, 2, 1'b1));
    send_item(make_item(sivu_pkg::OP_CMEQZ, 16, 3, 0, 0, 1'b0));
    it = make_item(sivu_pkg::OP_UMOV, 17, 1, 0, 0, 1'b0); it.lane_index = 4'd15;
    send_item(it);
    it = make_item(sivu_pkg::OP_SMOV, 18, 1, 0, 1, 1'b0); it.lane_index = 4'd9;
    it.wide_result = 1'b1; send_item(it);
    it = make_item(sivu_pkg::OP_SMOV, 19, 31, 0, 3, 1'b1); it.lane_index = 4'd1;
    it.wide_result = 1'b1; send_item(it);
    it = make_item(sivu_pkg::OP_SMOV, 20, 2, 0, 0, 1'b1); send_item(it);
    it = rand_item(); it.kind = 4'd14; send_item(it);
    it = rand_item(); it.kind = 4'd15; send_item(it);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_item(rand_item());
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure();
    hold_reqs = hold_reqs + 1;
    test_random(30);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_reqs = 0; hold_seen = 0; hold_left = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
    foreach (shadow_vregs[i]) shadow_vregs[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 26; recv_idle_pct = 53;
    test_random(140);
    test_backpressure();
    send_idle_pct = 53; recv_idle_pct = 26;
    test_random(130);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(130);
    wait_drain();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
design/sivu_pkg.sv
design/sivu_regfile.sv
design/sivu_exec.sv
design/simd_integer_vector_unit.sv
test/simd_integer_vector_unit_test.sv
